### hdl/swm_pkg.sv
// Shared types and constants for the star wildcard matcher.
// No dependencies; imported by every module under hdl.
package swm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

    localparam logic [7:0] STAR_BYTE = 8'h2A;

    localparam logic [1:0] OP_PAT_BYTE  = 2'd0;
    localparam logic [1:0] OP_NAME_BYTE = 2'd1;
    localparam logic [1:0] OP_PAT_END   = 2'd2;
    localparam logic [1:0] OP_NAME_END  = 2'd3;

    // Broadcast to every cell in a cycle
    typedef struct packed {
        logic       step;     // advance the active set by one name byte
        logic       restart;  // reload active set with position zero plus closure
        logic [7:0] chr;      // name byte for a step, pattern byte for a write
    } t_cell_cmd;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_result;

endpackage

### hdl/star_wildcard_matcher.sv
// Top level of the star wildcard matcher: a row of swm_cell positions,
// pattern length and flags, and an swm_out_buf on the result side.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready    | i_opcode, i_byte_value
//  result   | o_out_valid / i_out_ready  | o_matched, o_pattern_overflow
//
// One word per cycle for every opcode while o_in_ready is high; each name
// byte updates all pattern positions at once, with star runs resolved along
// the cell chain. An end-of-name word's result is registered in swm_out_buf.
// Input stalls only while two results wait unread in the output buffer.
// Reset: empty pattern in force, no results pending.
module star_wildcard_matcher
    import swm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    logic [LEN_W-1:0]     r_length;
    logic [LEN_W-1:0]     n_length;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_closed;
    logic                 n_closed;
    logic                 r_tail;      // active bit of the position past the last cell

    logic                 acc;
    logic                 op_pat;
    logic                 op_name;
    logic                 op_pend;
    logic                 op_nend;
    logic [LEN_W-1:0]     wr_pos;
    logic                 wr_ok;
    logic [PATTERN_MAX-1:0] wr_vec;
    logic [PATTERN_MAX-1:0] en_vec;
    logic [PATTERN_MAX-1:0] adv;
    logic [PATTERN_MAX-1:0] clo;
    logic [PATTERN_MAX-1:0] act;
    logic [PATTERN_MAX:0]   act_all;
    t_cell_cmd            cmd;
    t_result              res;
    logic                 push;
    logic                 full;
    t_result              out_data;

    assign o_in_ready = ~full;
    assign acc        = i_in_valid & o_in_ready;
    assign op_pat     = acc & (i_opcode == OP_PAT_BYTE);
    assign op_name    = acc & (i_opcode == OP_NAME_BYTE);
    assign op_pend    = acc & (i_opcode == OP_PAT_END);
    assign op_nend    = acc & (i_opcode == OP_NAME_END);

    // name words count only with a closed pattern
    assign push        = op_nend & r_closed;
    assign cmd.step    = op_name & r_closed;
    assign cmd.restart = op_pend | push;
    assign cmd.chr     = i_byte_value;

    // a pattern byte on a closed pattern starts over at position zero
    assign wr_pos = r_closed ? '0 : r_length;
    assign wr_ok  = (wr_pos < LEN_W'(PATTERN_MAX));

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            wr_vec[i] = op_pat & wr_ok & (wr_pos == LEN_W'(i));
            en_vec[i] = (LEN_W'(i) < r_length);
        end
    end

    always_comb begin
        n_length = r_length;
        n_ovf    = r_ovf;
        n_closed = r_closed;
        if (op_pat) begin
            n_closed = 1'b0;
            n_ovf    = (~r_closed & r_ovf) | ~wr_ok;
            if (wr_ok) begin
                n_length = wr_pos + LEN_W'(1);
            end
        end else if (op_pend) begin
            n_closed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_ovf    <= 1'b0;
            r_closed <= 1'b1;
            r_tail   <= 1'b0;
        end else begin
            r_length <= n_length;
            r_ovf    <= n_ovf;
            r_closed <= n_closed;
            if (cmd.step || cmd.restart) begin
                r_tail <= adv[PATTERN_MAX-1] | clo[PATTERN_MAX-1];
            end
        end
    end

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic adv_in;
        logic clo_in;
        if (g == 0) begin : g_head
            assign adv_in = cmd.restart;
            assign clo_in = 1'b0;
        end else begin : g_body
            assign adv_in = adv[g-1];
            assign clo_in = clo[g-1];
        end
        swm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_seed   ((g == 0) ? 1'b1 : 1'b0),
            .i_cmd    (cmd),
            .i_wr     (wr_vec[g]),
            .i_en     (en_vec[g]),
            .i_adv_in (adv_in),
            .i_clo_in (clo_in),
            .o_adv    (adv[g]),
            .o_clo    (clo[g]),
            .o_act    (act[g])
        );
    end

    assign act_all      = {r_tail, act};
    assign res.matched  = act_all[r_length] & ~r_ovf;
    assign res.overflow = r_ovf;

    swm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_matched          = out_data.matched;
    assign o_pattern_overflow = out_data.overflow;

endmodule

### hdl/swm_cell.sv
// One pattern position: stored pattern byte and its active bit.
// Depends on swm_pkg; chained left to right inside star_wildcard_matcher.
module swm_cell
    import swm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_seed,     // reset value of the active bit
    input  t_cell_cmd i_cmd,
    input  logic      i_wr,       // store i_cmd.chr as this position's byte
    input  logic      i_en,       // position lies inside the pattern
    input  logic      i_adv_in,   // left neighbor consumed a byte into this position
    input  logic      i_clo_in,   // left neighbor is an active star (empty run)
    output logic      o_adv,
    output logic      o_clo,
    output logic      o_act
);

    logic [7:0] r_byte;
    logic       r_act;
    logic       n_act;
    logic       star;
    logic       live;
    logic       hold;

    assign star  = (r_byte == STAR_BYTE);
    assign live  = r_act & i_en;
    // a star keeps its own position alive while it swallows the byte
    assign hold  = i_cmd.step & live & star;
    assign n_act = i_adv_in | hold | i_clo_in;

    assign o_clo = n_act & i_en & star;
    assign o_adv = i_cmd.step & live & ~star & (r_byte == i_cmd.chr);
    assign o_act = r_act;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_cmd.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_seed;
        end else if (i_cmd.step || i_cmd.restart) begin
            r_act <= n_act;
        end
    end

endmodule

### hdl/swm_out_buf.sv
// Two-word output buffer: output register plus skid stage.
// Depends on swm_pkg for the result word type.
module swm_out_buf
    import swm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_head_v;
    logic    r_skid_v;
    t_result r_head;
    t_result r_skid;
    logic    pop;

    assign pop     = r_head_v & i_ready;
    assign o_full  = r_skid_v;
    assign o_valid = r_head_v;
    assign o_data  = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (pop || !r_head_v) begin
                r_head_v <= r_skid_v | i_push;
                r_skid_v <= 1'b0;
            end else if (i_push) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_head_v) begin
            r_head <= r_skid_v ? r_skid : i_data;
        end
        if (r_head_v && !pop && i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
